// ===== sv/cht_pkg.sv =====
// Package for the cuckoo hash table: shared types, field widths and codes.
// No dependencies; used by cht_hash and cuckoo_hash_table.
`default_nettype none
package cht_pkg;

  localparam int KEY_BITS    = 60;
  localparam int CHAR_BITS   = 5;
  localparam int MAX_CHARS   = 12;
  localparam int EXP_PERIOD  = 10;
  localparam int PRIME_BITS  = 5;
  localparam int KIND_BITS   = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 64;

  localparam int DEF_TABLE_SIZE = 1024;
  localparam int DEF_MAX_KICKS  = 32;
  localparam int DEF_KEY_CHARS  = 12;

  localparam logic [PRIME_BITS-1:0] PRIME_ONE_RST = 5'd2;
  localparam logic [PRIME_BITS-1:0] PRIME_TWO_RST = 5'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_TWO = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_H1, S_H2, S_RD, S_CMP, S_KRD, S_KCMP, S_KH, S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== sv/cht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/cht_hash.sv =====
// Iterative polynomial hash: one character per cycle, using two multipliers.
// Depends on cht_pkg.
`default_nettype none
module cht_hash #(
  parameter int HW = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire cht_pkg::key_t                 key,
  input  wire logic [cht_pkg::PRIME_BITS-1:0] prime,
  output logic                               done,
  output logic [HW-1:0]                      hash
);

  localparam int CW = cht_pkg::CHAR_BITS;
  localparam int PRIME_BITS_W = cht_pkg::PRIME_BITS;

  logic                 busy;
  logic [3:0]           idx;
  logic [HW-1:0]        pw;
  logic [HW-1:0]        acc;
  cht_pkg::key_t        shreg;
  logic [PRIME_BITS_W-1:0] prime_r;

  logic [CW-1:0]        c;
  logic [HW+CW-1:0]     term;
  logic [HW+PRIME_BITS_W-1:0] pw_mul;
  logic                 last;

  assign c      = shreg[CW-1:0];
  assign term   = {{CW{1'b0}}, pw} * {{HW{1'b0}}, c};
  assign pw_mul = {{PRIME_BITS_W{1'b0}}, pw} * {{HW{1'b0}}, prime_r};
  assign last   = (c == '0) || (idx == 4'(cht_pkg::MAX_CHARS - 1));
  assign hash   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        shreg   <= key;
        prime_r <= prime;
        acc     <= '0;
        pw      <= HW'(1);
        idx     <= '0;
      end else if (busy) begin
        if (c != '0) begin
          acc <= acc + term[HW-1:0];
        end
        pw    <= (idx == 4'(cht_pkg::EXP_PERIOD - 1)) ? HW'(1) : pw_mul[HW-1:0];
        shreg <= shreg >> CW;
        idx   <= idx + 4'd1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/cuckoo_hash_table.sv =====
// Top level of the two-table cuckoo hash set: sequencer, config registers, tables.
// Depends on cht_pkg, cht_ram, cht_hash.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: kind; tdata: key
//  m_       | out       | m_tvalid/m_tready  | tdata: found, insert_failed, dropped_key
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (hash primes)
//
// Hashing: the shared unit takes one character per cycle, up to the first zero code or the
// last of MAX_CHARS characters, then hands the result over.
// Lookup/delete: two hashes, then table read (S_RD) and compare (S_CMP), then the result transfer.
// Insert of an absent key adds a table read (S_KRD) and write (S_KCMP) per kick, and each
// kick after the first also one hash; up to MAX_KICKS kicks.
// Clear: one sweep over all TABLE_SIZE entries, one entry of each table per cycle.
// Reset: the same clearing pass over all TABLE_SIZE entries runs first; s_tready stays low meanwhile.
// Stalls: one item at a time; the result is held in m_tdata until its transfer.
`default_nettype none
module cuckoo_hash_table #(
  parameter int TABLE_SIZE = cht_pkg::DEF_TABLE_SIZE,
  parameter int MAX_KICKS  = cht_pkg::DEF_MAX_KICKS,
  parameter int KEY_CHARS  = cht_pkg::DEF_KEY_CHARS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [cht_pkg::IN_DATA_W-1:0]     s_tdata,  // [59:0] key, rest zero
  input  wire logic [cht_pkg::KIND_BITS-1:0]     s_tuser,  // [1:0] kind
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [cht_pkg::OUT_DATA_W-1:0]         m_tdata,  // [0] found, [1] insert_failed,
                                                           // [61:2] dropped_key, rest zero
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cht_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cht_pkg::PRIME_BITS-1:0]    cfg_data
);

  localparam int HW = $clog2(TABLE_SIZE);
  localparam int KW = $clog2(MAX_KICKS + 1);
  localparam int KB = cht_pkg::KEY_BITS;
  localparam int CB = cht_pkg::CHAR_BITS;

  cht_pkg::state_t state, state_next;

  // Config registers; writes are always taken.
  logic [cht_pkg::PRIME_BITS-1:0] prime_one, prime_two;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_one <= cht_pkg::PRIME_ONE_RST;
      prime_two <= cht_pkg::PRIME_TWO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cht_pkg::CFG_PRIME_ONE: prime_one <= cfg_data;
        cht_pkg::CFG_PRIME_TWO: prime_two <= cfg_data;
        default: ;
      endcase
    end
  end

  // Normalize: keep characters up to the first zero code and at most KEY_CHARS of them.
  cht_pkg::key_t nkey;
  always_comb begin
    logic on;
    on   = 1'b1;
    nkey = '0;
    for (int i = 0; i < cht_pkg::MAX_CHARS; i++) begin
      if (s_tdata[i*CB +: CB] == '0 || i >= KEY_CHARS) begin
        on = 1'b0;
      end
      if (on) begin
        nkey[i*CB +: CB] = s_tdata[i*CB +: CB];
      end
    end
  end

  // Item and sequencer registers.
  cht_pkg::kind_t kind_r;
  cht_pkg::key_t  key_r, cur;
  logic [HW-1:0]  h1, h2, hcur, clr_cnt;
  logic           side, clr_op;
  logic [KW-1:0]  kicks;
  logic           res_found, res_fail;
  cht_pkg::key_t  res_drop;

  cht_pkg::kind_t kind_next;
  cht_pkg::key_t  key_next, cur_next, res_drop_next;
  logic [HW-1:0]  h1_next, h2_next, hcur_next, clr_cnt_next;
  logic           side_next, clr_op_next, res_found_next, res_fail_next;
  logic [KW-1:0]  kicks_next;

  // Shared hash unit.
  logic                           hs_start, hs_done;
  cht_pkg::key_t                  hs_key;
  logic [cht_pkg::PRIME_BITS-1:0] hs_prime;
  logic [HW-1:0]                  hs_hash;

  cht_hash #(.HW(HW)) u_hash (
    .clk(clk), .rst(rst), .start(hs_start), .key(hs_key), .prime(hs_prime),
    .done(hs_done), .hash(hs_hash)
  );

  // Tables.
  logic          we1, we2;
  logic [HW-1:0] wa1, wa2, ra1, ra2;
  cht_pkg::key_t wd1, wd2, rd1, rd2;

  cht_ram #(.WIDTH(KB), .DEPTH(TABLE_SIZE)) u_first (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(ra1), .rdata(rd1)
  );
  cht_ram #(.WIDTH(KB), .DEPTH(TABLE_SIZE)) u_second (
    .clk(clk), .we(we2), .waddr(wa2), .wdata(wd2), .raddr(ra2), .rdata(rd2)
  );

  assign s_tready = (state == cht_pkg::S_IDLE);
  assign m_tvalid = (state == cht_pkg::S_OUT);
  assign m_tdata  = {{(cht_pkg::OUT_DATA_W-KB-2){1'b0}}, res_drop, res_fail, res_found};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cht_pkg::S_CLEAR;
      clr_cnt <= '0;
      clr_op  <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      clr_op  <= clr_op_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_next;
    key_r     <= key_next;
    cur       <= cur_next;
    h1        <= h1_next;
    h2        <= h2_next;
    hcur      <= hcur_next;
    side      <= side_next;
    kicks     <= kicks_next;
    res_found <= res_found_next;
    res_fail  <= res_fail_next;
    res_drop  <= res_drop_next;
  end

  always_comb begin
    cht_pkg::key_t occ;
    logic [KW-1:0] kicks_inc;

    state_next     = state;
    kind_next      = kind_r;
    key_next       = key_r;
    cur_next       = cur;
    h1_next        = h1;
    h2_next        = h2;
    hcur_next      = hcur;
    side_next      = side;
    kicks_next     = kicks;
    clr_cnt_next   = clr_cnt;
    clr_op_next    = clr_op;
    res_found_next = res_found;
    res_fail_next  = res_fail;
    res_drop_next  = res_drop;

    hs_start = 1'b0;
    hs_key   = key_r;
    hs_prime = prime_one;

    we1 = 1'b0;
    we2 = 1'b0;
    wa1 = hcur;
    wa2 = hcur;
    wd1 = cur;
    wd2 = cur;
    ra1 = hcur;
    ra2 = hcur;

    occ       = side ? rd2 : rd1;
    kicks_inc = kicks + KW'(1);

    unique case (state)
      cht_pkg::S_CLEAR: begin
        // Sweep both tables to empty, one entry each per cycle.
        we1 = 1'b1;
        we2 = 1'b1;
        wa1 = clr_cnt;
        wa2 = clr_cnt;
        wd1 = '0;
        wd2 = '0;
        clr_cnt_next = clr_cnt + HW'(1);
        if (clr_cnt == HW'(TABLE_SIZE - 1)) begin
          clr_op_next = 1'b0;
          state_next  = clr_op ? cht_pkg::S_OUT : cht_pkg::S_IDLE;
        end
      end
      cht_pkg::S_IDLE: begin
        if (s_tvalid) begin
          kind_next      = cht_pkg::kind_t'(s_tuser);
          key_next       = nkey;
          res_found_next = 1'b0;
          res_fail_next  = 1'b0;
          res_drop_next  = '0;
          if (cht_pkg::kind_t'(s_tuser) == cht_pkg::KIND_CLEAR) begin
            clr_op_next  = 1'b1;
            clr_cnt_next = '0;
            state_next   = cht_pkg::S_CLEAR;
          end else if (nkey == '0) begin
            state_next = cht_pkg::S_OUT;
          end else begin
            hs_start   = 1'b1;
            hs_key     = nkey;
            hs_prime   = prime_one;
            state_next = cht_pkg::S_H1;
          end
        end
      end
      cht_pkg::S_H1: begin
        if (hs_done) begin
          h1_next    = hs_hash;
          hs_start   = 1'b1;
          hs_prime   = prime_two;
          state_next = cht_pkg::S_H2;
        end
      end
      cht_pkg::S_H2: begin
        if (hs_done) begin
          h2_next    = hs_hash;
          state_next = cht_pkg::S_RD;
        end
      end
      cht_pkg::S_RD: begin
        ra1        = h1;
        ra2        = h2;
        state_next = cht_pkg::S_CMP;
      end
      cht_pkg::S_CMP: begin
        state_next = cht_pkg::S_OUT;
        case (kind_r)
          cht_pkg::KIND_LOOKUP: begin
            res_found_next = (rd1 == key_r) || (rd2 == key_r);
          end
          cht_pkg::KIND_DELETE: begin
            // First table is checked before the second.
            wa1 = h1;
            wa2 = h2;
            wd1 = '0;
            wd2 = '0;
            if (rd1 == key_r) begin
              we1            = 1'b1;
              res_found_next = 1'b1;
            end else if (rd2 == key_r) begin
              we2            = 1'b1;
              res_found_next = 1'b1;
            end
          end
          default: begin
            if (rd1 == key_r || rd2 == key_r) begin
              res_found_next = 1'b1;
            end else begin
              // Start the kick chain in the first table at h1.
              cur_next   = key_r;
              side_next  = 1'b0;
              kicks_next = '0;
              hcur_next  = h1;
              state_next = cht_pkg::S_KRD;
            end
          end
        endcase
      end
      cht_pkg::S_KRD: begin
        state_next = cht_pkg::S_KCMP;
      end
      cht_pkg::S_KCMP: begin
        // Place the homeless key, evicting the occupant.
        we1 = ~side;
        we2 = side;
        if (occ == '0 || occ == cur) begin
          state_next = cht_pkg::S_OUT;
        end else if (kicks_inc == KW'(MAX_KICKS)) begin
          res_fail_next = 1'b1;
          res_drop_next = occ;
          state_next    = cht_pkg::S_OUT;
        end else begin
          cur_next   = occ;
          side_next  = ~side;
          kicks_next = kicks_inc;
          hs_start   = 1'b1;
          hs_key     = occ;
          hs_prime   = side ? prime_one : prime_two;
          state_next = cht_pkg::S_KH;
        end
      end
      cht_pkg::S_KH: begin
        if (hs_done) begin
          hcur_next  = hs_hash;
          state_next = cht_pkg::S_KRD;
        end
      end
      cht_pkg::S_OUT: begin
        if (m_tready) begin
          state_next = cht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cht_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
